[rtl/core/rbsv_pkg.sv]
`timescale 1ns / 1ps

package rbsv_pkg;

  localparam int MOD_BITS_DEF = 16;
  localparam int BYTE_W       = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int PC_W         = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

  // Microprogram step labels
  localparam logic [PC_W-1:0] ST_IDLE       = 4'd0;
  localparam logic [PC_W-1:0] ST_FOLD_SETUP = 4'd1;
  localparam logic [PC_W-1:0] ST_FOLD_MUL   = 4'd2;
  localparam logic [PC_W-1:0] ST_FOLD_END   = 4'd3;
  localparam logic [PC_W-1:0] ST_BASE_SETUP = 4'd4;
  localparam logic [PC_W-1:0] ST_BASE_MUL   = 4'd5;
  localparam logic [PC_W-1:0] ST_BASE_END   = 4'd6;
  localparam logic [PC_W-1:0] ST_TEST_E     = 4'd7;
  localparam logic [PC_W-1:0] ST_PMUL_SETUP = 4'd8;
  localparam logic [PC_W-1:0] ST_PMUL_MUL   = 4'd9;
  localparam logic [PC_W-1:0] ST_PMUL_END   = 4'd10;
  localparam logic [PC_W-1:0] ST_SQ_SETUP   = 4'd11;
  localparam logic [PC_W-1:0] ST_SQ_MUL     = 4'd12;
  localparam logic [PC_W-1:0] ST_SQ_END     = 4'd13;
  localparam logic [PC_W-1:0] ST_FINISH     = 4'd14;

  typedef enum logic [3:0] {
    OP_WAIT_IN,
    OP_FOLD_SETUP,
    OP_MUL_STEP,
    OP_FOLD_END,
    OP_BASE_SETUP,
    OP_BASE_END,
    OP_NOP,
    OP_PMUL_SETUP,
    OP_PMUL_END,
    OP_SQ_SETUP,
    OP_SQ_END,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_LOOP,
    C_NOT_LAST,
    C_E_ZERO,
    C_NOT_E0,
    C_WAIT_OUT
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_e op;
  } rbsv_ctrl_t;

  typedef struct packed {
    logic accept;
    logic cnt_more;
    logic last;
    logic e_zero;
    logic e_lsb;
    logic out_free;
  } rbsv_status_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_WAIT_IN, cond: C_WAIT_IN, target: ST_IDLE};
    unique case (pc)
      ST_IDLE:       w = '{op: OP_WAIT_IN,    cond: C_WAIT_IN,  target: ST_IDLE};
      ST_FOLD_SETUP: w = '{op: OP_FOLD_SETUP, cond: C_NEXT,     target: ST_IDLE};
      ST_FOLD_MUL:   w = '{op: OP_MUL_STEP,   cond: C_LOOP,     target: ST_IDLE};
      ST_FOLD_END:   w = '{op: OP_FOLD_END,   cond: C_NOT_LAST, target: ST_IDLE};
      ST_BASE_SETUP: w = '{op: OP_BASE_SETUP, cond: C_NEXT,     target: ST_IDLE};
      ST_BASE_MUL:   w = '{op: OP_MUL_STEP,   cond: C_LOOP,     target: ST_IDLE};
      ST_BASE_END:   w = '{op: OP_BASE_END,   cond: C_NEXT,     target: ST_IDLE};
      ST_TEST_E:     w = '{op: OP_NOP,        cond: C_E_ZERO,   target: ST_FINISH};
      ST_PMUL_SETUP: w = '{op: OP_PMUL_SETUP, cond: C_NOT_E0,   target: ST_SQ_SETUP};
      ST_PMUL_MUL:   w = '{op: OP_MUL_STEP,   cond: C_LOOP,     target: ST_IDLE};
      ST_PMUL_END:   w = '{op: OP_PMUL_END,   cond: C_NEXT,     target: ST_IDLE};
      ST_SQ_SETUP:   w = '{op: OP_SQ_SETUP,   cond: C_NEXT,     target: ST_IDLE};
      ST_SQ_MUL:     w = '{op: OP_MUL_STEP,   cond: C_LOOP,     target: ST_IDLE};
      ST_SQ_END:     w = '{op: OP_SQ_END,     cond: C_JUMP,     target: ST_TEST_E};
      ST_FINISH:     w = '{op: OP_FINISH,     cond: C_WAIT_OUT, target: ST_IDLE};
      default:       w = '{op: OP_WAIT_IN,    cond: C_JUMP,     target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/rbsv_useq.sv]
`timescale 1ns / 1ps

module rbsv_useq import rbsv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rbsv_status_t status_i,
  output rbsv_ctrl_t   ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d, pc_inc;
  ucode_t          word;

  assign word   = ucode_rom(pc_q);
  assign pc_inc = pc_q + PC_W'(1);

  always_comb begin
    pc_d = pc_q;
    unique case (word.cond)
      C_NEXT:     pc_d = pc_inc;
      C_JUMP:     pc_d = word.target;
      C_WAIT_IN:  pc_d = status_i.accept ? pc_inc : pc_q;
      C_LOOP:     pc_d = status_i.cnt_more ? pc_q : pc_inc;
      C_NOT_LAST: pc_d = status_i.last ? pc_inc : word.target;
      C_E_ZERO:   pc_d = status_i.e_zero ? word.target : pc_inc;
      C_NOT_E0:   pc_d = status_i.e_lsb ? pc_inc : word.target;
      C_WAIT_OUT: pc_d = status_i.out_free ? word.target : pc_q;
      default:    pc_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op = word.op;

endmodule

[rtl/core/rbsv_datapath.sv]
`timescale 1ns / 1ps

module rbsv_datapath import rbsv_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rbsv_ctrl_t           ctrl_i,
  output rbsv_status_t         status_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [MOD_BITS-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic [BYTE_W-1:0]    in_byte_i,
  input  logic                 in_last_i,
  input  logic [MOD_BITS-1:0]  in_sig_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [MOD_BITS-1:0]  out_value_o,
  output logic                 out_ok_o,
  output logic [MOD_BITS-1:0]  out_residue_o
);

  localparam int XW = MOD_BITS + BYTE_W;
  localparam int CW = $clog2(XW + 1);
  localparam int TW = MOD_BITS + 2;

  logic [MOD_BITS-1:0] mod_q, exp_q;
  logic                mode_q;
  logic [MOD_BITS-1:0] res_q, res_d;
  logic [XW-1:0]       x_q, x_d;
  logic [MOD_BITS-1:0] b_q, b_d, acc_q, acc_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [MOD_BITS-1:0] base_q, base_d, pw_q, pw_d, e_q, e_d, sig_q, sig_d;
  logic                last_q, last_d;
  logic                out_valid_q, out_valid_d;
  logic [MOD_BITS-1:0] out_value_q, out_value_d, out_res_q, out_res_d;
  logic                out_ok_q, out_ok_d;

  logic                accept, mod_small, res_lt_n, out_free;
  logic [TW-1:0]       t_sum, t_n, t_2n, n_ext;
  logic [MOD_BITS-1:0] step_red, fin_value;

  assign accept    = in_valid_i && (ctrl_i.op == OP_WAIT_IN);
  assign mod_small = ~|mod_q[MOD_BITS-1:1];
  assign res_lt_n  = res_q < mod_q;
  assign out_free  = !out_valid_q || out_ready_i;

  // One step of interleaved shift-add reduction: acc and b below n keep the
  // sum under 3n, so at most two subtractions of n are needed.
  assign n_ext = TW'(mod_q);
  assign t_sum = {1'b0, acc_q, 1'b0} + (x_q[XW-1] ? TW'(b_q) : TW'(0));
  assign t_n   = t_sum - n_ext;
  assign t_2n  = t_sum - {n_ext[TW-2:0], 1'b0};

  always_comb begin
    if (t_sum >= {n_ext[TW-2:0], 1'b0}) begin
      step_red = t_2n[MOD_BITS-1:0];
    end else if (t_sum >= n_ext) begin
      step_red = t_n[MOD_BITS-1:0];
    end else begin
      step_red = t_sum[MOD_BITS-1:0];
    end
  end

  assign fin_value = mod_small ? '0 : pw_q;

  always_comb begin
    res_d       = res_q;
    x_d         = x_q;
    b_d         = b_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    pw_d        = pw_q;
    e_d         = e_q;
    sig_d       = sig_q;
    last_d      = last_q;
    out_value_d = out_value_q;
    out_res_d   = out_res_q;
    out_ok_d    = out_ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (ctrl_i.op)
      OP_WAIT_IN: begin
        if (accept) begin
          x_d    = {res_q, in_byte_i};
          sig_d  = in_sig_i;
          last_d = in_last_i;
        end
      end
      OP_FOLD_SETUP: begin
        b_d = MOD_BITS'(1);
        if (res_lt_n) begin
          // Residue already reduced: shift in the byte only
          acc_d = res_q;
          x_d   = {x_q[BYTE_W-1:0], {MOD_BITS{1'b0}}};
          cnt_d = CW'(BYTE_W);
        end else begin
          acc_d = '0;
          cnt_d = CW'(XW);
        end
      end
      OP_MUL_STEP: begin
        acc_d = step_red;
        x_d   = {x_q[XW-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
      end
      OP_FOLD_END: begin
        res_d = mod_small ? '0 : acc_q;
      end
      OP_BASE_SETUP: begin
        x_d   = {(mode_q ? sig_q : res_q), {BYTE_W{1'b0}}};
        b_d   = MOD_BITS'(1);
        acc_d = '0;
        cnt_d = CW'(MOD_BITS);
      end
      OP_BASE_END: begin
        base_d = acc_q;
        pw_d   = MOD_BITS'(1);
        e_d    = exp_q;
      end
      OP_NOP: begin
      end
      OP_PMUL_SETUP: begin
        x_d   = {pw_q, {BYTE_W{1'b0}}};
        b_d   = base_q;
        acc_d = '0;
        cnt_d = CW'(MOD_BITS);
      end
      OP_PMUL_END: begin
        pw_d = acc_q;
      end
      OP_SQ_SETUP: begin
        x_d   = {base_q, {BYTE_W{1'b0}}};
        b_d   = base_q;
        acc_d = '0;
        cnt_d = CW'(MOD_BITS);
      end
      OP_SQ_END: begin
        base_d = acc_q;
        e_d    = {1'b0, e_q[MOD_BITS-1:1]};
      end
      OP_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = fin_value;
          out_res_d   = res_q;
          out_ok_d    = mode_q && (fin_value == res_q);
          res_d       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= MOD_BITS'(2);
      exp_q       <= MOD_BITS'(1);
      mode_q      <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODULUS:  mod_q  <= cfg_wdata_i;
          CFG_EXPONENT: exp_q  <= cfg_wdata_i;
          CFG_MODE:     mode_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    b_q         <= b_d;
    acc_q       <= acc_d;
    cnt_q       <= cnt_d;
    base_q      <= base_d;
    pw_q        <= pw_d;
    e_q         <= e_d;
    sig_q       <= sig_d;
    last_q      <= last_d;
    out_value_q <= out_value_d;
    out_res_q   <= out_res_d;
    out_ok_q    <= out_ok_d;
  end

  assign status_o.accept   = accept;
  assign status_o.cnt_more = cnt_q > CW'(1);
  assign status_o.last     = last_q;
  assign status_o.e_zero   = ~|e_q;
  assign status_o.e_lsb    = e_q[0];
  assign status_o.out_free = out_free;

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_ok_o      = out_ok_q;
  assign out_residue_o = out_res_q;

endmodule

[rtl/core/rsa_byte_stream_sign_verify_core.sv]
`timescale 1ns / 1ps

// Byte-stream RSA sign / verify core. Message bytes are folded one per
// transaction into a residue, residue = (residue * 256 + byte) mod modulus;
// the transaction flagged by tlast then triggers square-and-multiply
// exponentiation and produces one result transaction: the signature in sign
// mode (mode 0), or signature_in^exponent mod modulus plus a match flag in
// verify mode (mode 1). A modulus below two reduces everything to zero. All
// arithmetic runs on one bit-serial modular multiplier, driven step by step
// from a small microprogram ROM, and the core takes one byte at a time.
// A byte folds only itself into the residue when the held residue is below
// the modulus, and the whole residue and byte otherwise (with a zero modulus,
// or after the modulus was rewritten mid message). A last byte adds a base
// reduction, then for each exponent bit up to the highest set one a squaring
// plus a multiplication when the bit is set, then a finish step. The result
// sits in an output register, so the next message can start while it waits
// to be taken; the finish step of that next message holds until the register
// has been emptied. Write configuration only while idle.
module rsa_byte_stream_sign_verify_core import rbsv_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEF,
  localparam int IN_TDATA_W  = ((BYTE_W + MOD_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((2 * MOD_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration: 0 modulus, 1 exponent, 2 mode
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [MOD_BITS-1:0]    cfg_wdata_i,
  // Byte input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // msg_byte, signature_in
  input  logic                   s_axis_tlast,
  // Result output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // value_out, message_residue
  output logic                   m_axis_tuser    // signature_ok
);

  rbsv_ctrl_t          ctrl;
  rbsv_status_t        status;
  logic [MOD_BITS-1:0] value_out, message_residue;

  // Sequencer: step counter and control ROM
  rbsv_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Datapath: config registers, residue, modular multiplier, output register
  rbsv_datapath #(
    .MOD_BITS (MOD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_byte_i     (s_axis_tdata[BYTE_W-1:0]),
    .in_last_i     (s_axis_tlast),
    .in_sig_i      (s_axis_tdata[BYTE_W +: MOD_BITS]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_value_o   (value_out),
    .out_ok_o      (m_axis_tuser),
    .out_residue_o (message_residue)
  );

  // Take a byte only while the microprogram waits at its idle step
  assign s_axis_tready = (ctrl.op == OP_WAIT_IN);

  assign m_axis_tdata = OUT_TDATA_W'({message_residue, value_out});

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the byte-stream RSA sign / verify core. Message
// bytes are queued by the stimulus process, driven one transaction at a
// time by a clocked driver and folded into a local residue as each
// transaction is accepted; a last byte also computes the expected signature
// or verify outcome. The monitor compares every result transaction, field
// by field, with the oldest expectation.
module testbench;
  import rbsv_pkg::*;

  localparam int WORD_W      = 16;
  localparam int IN_TDATA_W  = 24;   // msg_byte, signature_in
  localparam int OUT_TDATA_W = 32;   // value_out, message_residue

  // Index beyond the register map: the core must drop writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Real textbook key: n = 251 * 241, e * d = 1 mod 60000
  localparam logic [WORD_W-1:0] KEY_N = 16'd60491;
  localparam logic [WORD_W-1:0] KEY_E = 16'd7;
  localparam logic [WORD_W-1:0] KEY_D = 16'd17143;

  // Room for the slowest byte fold to finish, with margin to spare
  localparam int SETTLE_CYCLES = 48;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_BYTES   = 104;

  typedef enum int {PH_KEY_SIGN, PH_KEY_VERIFY, PH_RANDOM} phase_kind_e;

  typedef struct {
    logic [7:0]        msg;
    logic              last;
    logic [WORD_W-1:0] sig;
  } msg_byte_t;

  typedef struct {
    logic [WORD_W-1:0] value;
    logic              ok;
    logic [WORD_W-1:0] residue;
  } sign_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [WORD_W-1:0]      cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // msg_byte, signature_in
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // value_out, message_residue
  logic                   m_axis_tuser;        // signature_ok

  // Local copy of the register file, as the core should hold it
  logic [WORD_W-1:0] cfg_modulus = 16'd2;
  logic [WORD_W-1:0] cfg_exponent = 16'd1;
  logic              cfg_mode = 1'b0;

  msg_byte_t    pending_bytes[$];
  msg_byte_t    drive_item;
  sign_result_t expected_results[$];
  logic [WORD_W-1:0] fold_acc = '0;

  int  bytes_queued = 0;
  int  bytes_accepted = 0;
  int  mismatches = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  tail_quiet = 1'b0;

  rsa_byte_stream_sign_verify_core #(
    .MOD_BITS(WORD_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // A modulus of 0 or 1 collapses every value to zero
  function automatic logic [WORD_W-1:0] mod_reduce(input logic [31:0] x,
                                                   input logic [WORD_W-1:0] n);
    if (n < 2) return '0;
    return WORD_W'(x % n);
  endfunction

  // residue * 256 + byte is just the concatenation of the two
  function automatic logic [WORD_W-1:0] fold_step(input logic [WORD_W-1:0] acc,
                                                  input logic [7:0] b,
                                                  input logic [WORD_W-1:0] n);
    return mod_reduce({8'h00, acc, b}, n);
  endfunction

  // Right-to-left square and multiply over every exponent bit
  function automatic logic [WORD_W-1:0] mod_power(input logic [WORD_W-1:0] base,
                                                  input logic [WORD_W-1:0] ex,
                                                  input logic [WORD_W-1:0] n);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] sq;
    acc = mod_reduce(32'd1, n);
    sq  = mod_reduce(32'(base), n);
    for (int i = 0; i < WORD_W; i++) begin
      if (ex[i]) acc = mod_reduce(32'(acc) * 32'(sq), n);
      sq = mod_reduce(32'(sq) * 32'(sq), n);
    end
    return acc;
  endfunction

  // Write one register and mirror it locally once the core has taken it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODULUS:  cfg_modulus = data;
      CFG_EXPONENT: cfg_exponent = data;
      CFG_MODE:     cfg_mode = data[0];
      default:      ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] msg, input logic last,
                           input logic [WORD_W-1:0] sig);
    pending_bytes.push_back('{msg: msg, last: last, sig: sig});
    bytes_queued++;
  endtask

  // Hold until every queued byte is taken and every result has come back,
  // then let a trailing byte fold finish before the registers are touched
  task automatic drain_core();
    while (bytes_accepted != bytes_queued || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Byte driver: predict on every accepted transaction, then present the
  // next queued byte or idle for a random burst
  always @(posedge clk_i) begin
    logic [WORD_W-1:0] folded;
    sign_result_t      predicted;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      fold_acc = '0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_accepted++;
        folded = fold_step(fold_acc, drive_item.msg, cfg_modulus);
        if (drive_item.last) begin
          // Sign mode raises the residue, verify mode the supplied signature
          predicted.residue = folded;
          predicted.value   = mod_power(cfg_mode ? drive_item.sig : folded,
                                        cfg_exponent, cfg_modulus);
          predicted.ok      = cfg_mode && (predicted.value == folded);
          expected_results.push_back(predicted);
          fold_acc = '0;
        end else begin
          fold_acc = folded;
        end
      end
      // Advance only when the current transaction has gone or none is up
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0 && !tail_quiet &&
                     $urandom_range(0, 15) == 0) begin
          gap_left = $urandom_range(1, 19) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          drive_item = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {drive_item.sig, drive_item.msg};
          s_axis_tlast  <= drive_item.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted result, stall tready in bursts
  always @(posedge clk_i) begin
    sign_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h / %b", $time,
                   m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[15:0] !== want.value) begin
            $display("%0t: value_out mismatch, expected %h, actual %h", $time,
                     want.value, m_axis_tdata[15:0]);
            mismatches++;
          end
          if (m_axis_tuser !== want.ok) begin
            $display("%0t: signature_ok mismatch, expected %b, actual %b", $time,
                     want.ok, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[31:16] !== want.residue) begin
            $display("%0t: message_residue mismatch, expected %h, actual %h", $time,
                     want.residue, m_axis_tdata[31:16]);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corner cases, then randomised phases of messages
  initial begin
    phase_kind_e       kind;
    int                phase_bytes;
    int                msg_len;
    logic [WORD_W-1:0] msg_res;
    logic [WORD_W-1:0] sig;
    logic [7:0]        b;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values (modulus 2, exponent 1, sign); the stray write must vanish
    write_reg(CFG_UNUSED, 16'hFFFF);
    push_byte(8'hFF, 1'b1, 16'hFFFF);
    push_byte(8'h00, 1'b0, 16'h0000);
    push_byte(8'h01, 1'b1, 16'h0000);
    drain_core();

    // Largest modulus and exponent; mode bits above bit 0 are dropped
    write_reg(CFG_MODULUS, 16'hFFFF);
    write_reg(CFG_EXPONENT, 16'hFFFF);
    write_reg(CFG_MODE, 16'hFFFE);
    push_byte(8'hFF, 1'b0, 16'h0000);
    push_byte(8'hFF, 1'b0, 16'hFFFF);
    push_byte(8'hFF, 1'b1, 16'h0000);
    push_byte(8'h00, 1'b1, 16'hFFFF);
    push_byte(8'h80, 1'b1, 16'hFFFF);
    drain_core();

    // Verify at full width, signature at both extremes
    write_reg(CFG_MODE, 16'h0001);
    push_byte(8'hFF, 1'b0, 16'h0000);
    push_byte(8'h00, 1'b1, 16'hFFFF);
    push_byte(8'h12, 1'b1, 16'h0000);
    drain_core();

    // Exponent zero gives one; a residue of one then matches
    write_reg(CFG_EXPONENT, 16'h0000);
    push_byte(8'h00, 1'b1, 16'h1234);
    push_byte(8'h01, 1'b1, 16'h0000);
    drain_core();

    // Modulus zero (verify, which matches), then one (sign): all reduces to zero
    write_reg(CFG_MODULUS, 16'h0000);
    write_reg(CFG_EXPONENT, 16'h0003);
    push_byte(8'hAB, 1'b0, 16'h5555);
    push_byte(8'hCD, 1'b1, 16'h5555);
    drain_core();
    write_reg(CFG_MODULUS, 16'h0001);
    write_reg(CFG_MODE, 16'hFFFE);
    push_byte(8'h77, 1'b1, 16'hAAAA);
    drain_core();

    // Signature not below the modulus is reduced first
    write_reg(CFG_MODULUS, 16'h0003);
    write_reg(CFG_EXPONENT, 16'h0001);
    write_reg(CFG_MODE, 16'h0001);
    push_byte(8'h05, 1'b1, 16'h0005);
    push_byte(8'h04, 1'b1, 16'hFFFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_core();
      if (p == 0) kind = PH_KEY_SIGN;
      else if (p == 1) kind = PH_KEY_VERIFY;
      else kind = phase_kind_e'($urandom_range(0, 2));

      case (kind)
        PH_KEY_SIGN: begin
          write_reg(CFG_MODULUS, KEY_N);
          write_reg(CFG_EXPONENT, KEY_D);
          write_reg(CFG_MODE, 16'h0000);
        end
        PH_KEY_VERIFY: begin
          write_reg(CFG_MODULUS, KEY_N);
          write_reg(CFG_EXPONENT, KEY_E);
          write_reg(CFG_MODE, 16'h0001);
        end
        default: begin
          write_reg(CFG_MODULUS, ($urandom_range(0, 3) == 0) ?
                    16'($urandom_range(2, 300)) : 16'($urandom_range(2, 65535)));
          write_reg(CFG_EXPONENT, ($urandom_range(0, 4) == 0) ?
                    16'($urandom_range(0, 2)) : 16'($urandom));
          write_reg(CFG_MODE, 16'($urandom));
        end
      endcase

      // Drop all idling for the closing phase
      if (p == NUM_PHASES - 1) tail_quiet = 1'b1;

      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        msg_res = '0;
        for (int i = 0; i < msg_len; i++) begin
          case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
          endcase
          msg_res = fold_step(msg_res, b, cfg_modulus);
          if (i < msg_len - 1) begin
            push_byte(b, 1'b0, 16'($urandom));
          end else begin
            sig = 16'($urandom);
            if (cfg_mode && kind == PH_KEY_VERIFY && $urandom_range(0, 3) != 0) begin
              // Genuine signature, now and then corrupted in one bit
              sig = mod_power(msg_res, KEY_D, KEY_N);
              if ($urandom_range(0, 4) == 0) sig[$urandom_range(0, 15)] ^= 1'b1;
            end else if (cfg_mode && cfg_exponent == 1 && $urandom_range(0, 1) == 1) begin
              sig = msg_res;
            end
            // Lift the signature above the modulus now and then
            if (cfg_mode && sig <= 16'hFFFF - cfg_modulus && $urandom_range(0, 3) == 0)
              sig = sig + cfg_modulus;
            push_byte(b, 1'b1, sig);
          end
        end
        phase_bytes += msg_len;
      end
    end

    drain_core();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
